// ===== rtl/core/khaa_pkg.sv =====
// shared types, key code table and register map of the hold-key auto-repeat engine
package khaa_pkg;

    // default sizes
    localparam int DEF_SLOTS     = 6;
    localparam int DEF_TIME_BITS = 32;

    // code table covers up to this many slots
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_IDX_W  = 4;

    // register map
    localparam logic [2:0] CFG_HOLD_DELAY   = 3'd0;
    localparam logic [2:0] CFG_BASE_PERIOD  = 3'd1;
    localparam logic [2:0] CFG_TIER1_PERIOD = 3'd2;
    localparam logic [2:0] CFG_TIER2_PERIOD = 3'd3;
    localparam logic [2:0] CFG_TIER3_PERIOD = 3'd4;
    localparam logic [2:0] CFG_TIER_LENGTH  = 3'd5;
    localparam logic [2:0] CFG_ACCEL_FIRST  = 3'd6;

    // register reset values
    localparam logic [15:0] RST_HOLD_DELAY   = 16'd500;
    localparam logic [15:0] RST_BASE_PERIOD  = 16'd200;
    localparam logic [15:0] RST_TIER1_PERIOD = 16'd100;
    localparam logic [15:0] RST_TIER2_PERIOD = 16'd67;
    localparam logic [15:0] RST_TIER3_PERIOD = 16'd50;
    localparam logic [15:0] RST_TIER_LENGTH  = 16'd1000;
    localparam logic [2:0]  RST_ACCEL_FIRST  = 3'd2;

    // command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // press and release codes per slot
    localparam logic [7:0] PRESS_CODE [TABLE_SLOTS] = '{
        8'd56, 8'd62, 8'd198, 8'd200, 8'd194, 8'd196,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };
    localparam logic [7:0] RELEASE_CODE [TABLE_SLOTS] = '{
        8'd57, 8'd63, 8'd199, 8'd201, 8'd195, 8'd197,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };
    localparam logic [TABLE_SLOTS-1:0] CODE_VALID = 16'h003F;

    // configuration registers as seen by the engine
    typedef struct packed {
        logic [15:0] hold_delay;
        logic [15:0] base_period;
        logic [15:0] tier1_period;
        logic [15:0] tier2_period;
        logic [15:0] tier3_period;
        logic [15:0] tier_length;
        logic [2:0]  accel_first;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                  is_tick;
        logic                  hit;
        logic                  is_press;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  side;
        logic [31:0]           now;
    } qitem_t;

endpackage

// ===== rtl/core/khaa_front.sv =====
// front end: accepts beats, matches key codes and queues classified items
module khaa_front #(
    parameter int SLOTS = khaa_pkg::DEF_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [7:0]         key_code,
    input  logic               panel_side,
    input  logic [31:0]        now_ms,
    output logic               pop_valid,
    input  logic               pop_ready,
    output khaa_pkg::qitem_t   pop_item
);
    import khaa_pkg::*;

    qitem_t     cls;
    qitem_t     q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    // code match, lowest slot wins
    always_comb
    begin
        cls          = '0;
        cls.is_tick  = (command == CMD_TICK);
        cls.side     = panel_side;
        cls.now      = now_ms;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (CODE_VALID[s] && (key_code == PRESS_CODE[s] || key_code == RELEASE_CODE[s]))
            begin
                cls.hit      = 1'b1;
                cls.is_press = (key_code == PRESS_CODE[s]);
                cls.slot     = SLOT_IDX_W'(s);
            end
        end
        if (cls.is_tick)
        begin
            cls.hit = 1'b0;
        end
    end

    assign in_ready  = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = pop_valid && pop_ready;

    // two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/khaa_back.sv =====
// back end: per-slot hold state, tick walker and result register
module khaa_back #(
    parameter int SLOTS     = khaa_pkg::DEF_SLOTS,
    parameter int TIME_BITS = khaa_pkg::DEF_TIME_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  khaa_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  khaa_pkg::qitem_t  pop_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              consumed,
    output logic              fire,
    output logic [2:0]        slot,
    output logic              fire_side,
    output logic              last
);
    import khaa_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = (TIME_BITS > 18) ? TIME_BITS : 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_LOAD,
        ST_TEST,
        ST_FLUSH
    } state_t;

    state_t                state_reg;
    logic [SLOTS-1:0]      held_reg;
    logic                  side_reg  [SLOTS];
    logic [TIME_BITS-1:0]  press_reg [SLOTS];
    logic [TIME_BITS-1:0]  fired_reg [SLOTS];

    logic                  item_hit_reg;
    logic                  item_press_reg;
    logic [SLOT_W-1:0]     item_slot_reg;
    logic                  item_side_reg;
    logic [TIME_BITS-1:0]  item_now_reg;

    logic [SLOT_W-1:0]     idx_reg;
    logic [TIME_BITS-1:0]  hold_age_reg;
    logic [TIME_BITS-1:0]  since_reg;
    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic                  pend_side_reg;

    logic [17:0]           thr1_reg;
    logic [17:0]           thr2_reg;
    logic [17:0]           thr3_reg;

    logic                  out_valid_reg;
    logic                  consumed_reg;
    logic                  fire_reg;
    logic [2:0]            slot_reg;
    logic                  fire_side_reg;
    logic                  last_reg;

    logic                  can_emit;
    logic                  emit;
    logic                  last_idx;
    logic [CMP_W-1:0]      held_cmp;
    logic                  past_delay;
    logic                  accel;
    logic [15:0]           period;
    logic                  slot_fires;
    logic                  key_held;

    assign can_emit  = !out_valid_reg || out_ready;
    assign last_idx  = (idx_reg == SLOT_W'(SLOTS - 1));
    assign pop_ready = (state_reg == ST_IDLE);
    assign key_held  = held_reg[item_slot_reg];

    // repeat decision for the slot under test
    always_comb
    begin
        held_cmp   = CMP_W'(hold_age_reg);
        past_delay = (held_cmp >= CMP_W'(cfg.hold_delay));
        accel      = ((SLOT_W + 3)'(idx_reg) >= (SLOT_W + 3)'(cfg.accel_first));
        period     = cfg.base_period;
        if (accel)
        begin
            if (held_cmp >= CMP_W'(thr3_reg))
            begin
                period = cfg.tier3_period;
            end
            else if (held_cmp >= CMP_W'(thr2_reg))
            begin
                period = cfg.tier2_period;
            end
            else if (held_cmp >= CMP_W'(thr1_reg))
            begin
                period = cfg.tier1_period;
            end
        end
        slot_fires = past_delay && (since_reg >= TIME_BITS'(period));
    end

    // a result beat is loaded this cycle
    always_comb
    begin
        case (state_reg)
            ST_KEY:   emit = can_emit;
            ST_TEST:  emit = slot_fires && pend_valid_reg && can_emit;
            ST_FLUSH: emit = pend_valid_reg && can_emit;
            default:  emit = 1'b0;
        endcase
    end

    // tier boundaries as delay plus multiples of the tier length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr1_reg <= 18'd0;
            thr2_reg <= 18'd0;
            thr3_reg <= 18'd0;
        end
        else
        begin
            thr1_reg <= 18'(cfg.hold_delay) + 18'(cfg.tier_length);
            thr2_reg <= 18'(cfg.hold_delay) + {1'b0, cfg.tier_length, 1'b0};
            thr3_reg <= 18'(cfg.hold_delay) + 18'(cfg.tier_length)
                        + {1'b0, cfg.tier_length, 1'b0};
        end
    end

    // sequencer, slot state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                side_reg[s]  <= 1'b0;
                press_reg[s] <= '0;
                fired_reg[s] <= '0;
            end
            item_hit_reg   <= 1'b0;
            item_press_reg <= 1'b0;
            item_slot_reg  <= '0;
            item_side_reg  <= 1'b0;
            item_now_reg   <= '0;
            idx_reg        <= '0;
            hold_age_reg   <= '0;
            since_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_side_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            consumed_reg   <= 1'b0;
            fire_reg       <= 1'b0;
            slot_reg       <= 3'd0;
            fire_side_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        item_hit_reg   <= pop_item.hit;
                        item_press_reg <= pop_item.is_press;
                        item_slot_reg  <= SLOT_W'(pop_item.slot);
                        item_side_reg  <= pop_item.side;
                        item_now_reg   <= TIME_BITS'(pop_item.now);
                        idx_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= pop_item.is_tick ? ST_LOAD : ST_KEY;
                    end
                end

                // single result of a key event
                ST_KEY:
                begin
                    if (can_emit)
                    begin
                        last_reg <= 1'b1;
                        if (item_hit_reg && item_press_reg)
                        begin
                            consumed_reg             <= 1'b1;
                            fire_reg                 <= 1'b1;
                            slot_reg                 <= 3'(item_slot_reg);
                            fire_side_reg            <= item_side_reg;
                            held_reg[item_slot_reg]  <= 1'b1;
                            side_reg[item_slot_reg]  <= item_side_reg;
                            press_reg[item_slot_reg] <= item_now_reg;
                            fired_reg[item_slot_reg] <= item_now_reg;
                        end
                        else if (item_hit_reg && key_held)
                        begin
                            consumed_reg            <= 1'b1;
                            fire_reg                <= 1'b0;
                            slot_reg                <= 3'(item_slot_reg);
                            fire_side_reg           <= 1'b0;
                            held_reg[item_slot_reg] <= 1'b0;
                        end
                        else
                        begin
                            consumed_reg  <= 1'b0;
                            fire_reg      <= 1'b0;
                            slot_reg      <= 3'd0;
                            fire_side_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                // time differences of one held slot
                ST_LOAD:
                begin
                    if (held_reg[idx_reg])
                    begin
                        hold_age_reg <= item_now_reg - press_reg[idx_reg];
                        since_reg    <= item_now_reg - fired_reg[idx_reg];
                        state_reg    <= ST_TEST;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end

                // fire test; a found fire releases the previous one
                ST_TEST:
                begin
                    if (!(slot_fires && pend_valid_reg && !can_emit))
                    begin
                        if (slot_fires)
                        begin
                            if (pend_valid_reg)
                            begin
                                consumed_reg  <= 1'b0;
                                fire_reg      <= 1'b1;
                                slot_reg      <= 3'(pend_slot_reg);
                                fire_side_reg <= pend_side_reg;
                                last_reg      <= 1'b0;
                            end
                            pend_valid_reg     <= 1'b1;
                            pend_slot_reg      <= idx_reg;
                            pend_side_reg      <= side_reg[idx_reg];
                            fired_reg[idx_reg] <= item_now_reg;
                        end
                        if (last_idx)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + SLOT_W'(1);
                            state_reg <= ST_LOAD;
                        end
                    end
                end

                // final fire of the tick carries last
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (can_emit)
                    begin
                        consumed_reg   <= 1'b0;
                        fire_reg       <= 1'b1;
                        slot_reg       <= 3'(pend_slot_reg);
                        fire_side_reg  <= pend_side_reg;
                        last_reg       <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign consumed  = consumed_reg;
    assign fire      = fire_reg;
    assign slot      = slot_reg;
    assign fire_side = fire_side_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/key_hold_autorepeat_accel_top.sv =====
// top level of the hold-key auto-repeat engine with configuration registers
// Hold-key auto-repeat engine. Each input beat is a key event or a time tick.
// A key event yields exactly one result beat (consumed, fire, slot, side): it
// is taken from the input queue in the idle state and its result is loaded
// in the key state, which waits while the result register is stalled. A tick
// walks the slots one at a time through a single time-difference unit; it is
// taken in the idle state, passes a slot that is not held in the load state
// and a held slot in the load and test states, and closes in the flush state;
// test and flush may wait while the result register is stalled. A tick that
// fires nothing yields no beat; otherwise the final fire carries last. A
// two-entry queue lets new beats enter while the walker or the result
// register is busy. Configuration writes, whose tier boundaries are
// registered once more, must only be made while the engine is idle.
module key_hold_autorepeat_accel_top #(
    parameter int SLOTS     = khaa_pkg::DEF_SLOTS,
    parameter int TIME_BITS = khaa_pkg::DEF_TIME_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  key_code,
    input  logic        panel_side,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        consumed,
    output logic        fire,
    output logic [2:0]  slot,
    output logic        fire_side,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import khaa_pkg::*;

    cfg_t   cfg_reg;
    logic   pop_valid;
    logic   pop_ready;
    qitem_t pop_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_delay   <= RST_HOLD_DELAY;
            cfg_reg.base_period  <= RST_BASE_PERIOD;
            cfg_reg.tier1_period <= RST_TIER1_PERIOD;
            cfg_reg.tier2_period <= RST_TIER2_PERIOD;
            cfg_reg.tier3_period <= RST_TIER3_PERIOD;
            cfg_reg.tier_length  <= RST_TIER_LENGTH;
            cfg_reg.accel_first  <= RST_ACCEL_FIRST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HOLD_DELAY:   cfg_reg.hold_delay   <= cfg_data;
                CFG_BASE_PERIOD:  cfg_reg.base_period  <= cfg_data;
                CFG_TIER1_PERIOD: cfg_reg.tier1_period <= cfg_data;
                CFG_TIER2_PERIOD: cfg_reg.tier2_period <= cfg_data;
                CFG_TIER3_PERIOD: cfg_reg.tier3_period <= cfg_data;
                CFG_TIER_LENGTH:  cfg_reg.tier_length  <= cfg_data;
                CFG_ACCEL_FIRST:  cfg_reg.accel_first  <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // classify and queue
    khaa_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .key_code   (key_code),
        .panel_side (panel_side),
        .now_ms     (now_ms),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // carry out key events and ticks
    khaa_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .consumed  (consumed),
        .fire      (fire),
        .slot      (slot),
        .fire_side (fire_side),
        .last      (last)
    );

endmodule

// ===== rtl/core/khaa_checker.sv =====
// port-level assertions for the hold-key auto-repeat engine and their bind
module khaa_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        command,
    input logic [7:0]  key_code,
    input logic        panel_side,
    input logic [31:0] now_ms,
    input logic        out_valid,
    input logic        out_ready,
    input logic        consumed,
    input logic        fire,
    input logic [2:0]  slot,
    input logic        fire_side,
    input logic        last,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(slot) && $stable(last)))
        else $error("result beat changed while stalled");

    // a consumed key event is always a single closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && consumed) |-> last)
        else $error("consumed beat without last");

    // a beat that does not fire belongs to a key event and closes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fire) |-> last)
        else $error("non-firing beat without last");

    // unmatched key events report slot and side as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !consumed && !fire) |-> (slot == 3'd0 && fire_side == 1'b0))
        else $error("unmatched beat with nonzero slot or side");

endmodule

bind key_hold_autorepeat_accel_top khaa_port_checks u_port_checks (.*);
